// ===== src/pls_pkg.sv =====
// ----------------------------------------------------------------------------
// pls_pkg - shared definitions for the positional list store
// Capacity, widths and request/status codes.
// ----------------------------------------------------------------------------
package pls_pkg;

    localparam int CAPACITY = 32;
    localparam int DATA_W   = 32;
    localparam int POS_W    = 6;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int LEN_W    = $clog2(CAPACITY + 1);
    localparam int CMP_W    = (LEN_W > POS_W) ? LEN_W : POS_W;

    typedef enum logic [1:0] {
        REQ_INSERT = 2'd0,
        REQ_REMOVE = 2'd1,
        REQ_DUMP   = 2'd2
    } req_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_OOB   = 2'd1,
        ST_FULL  = 2'd2,
        ST_EMPTY = 2'd3
    } status_t;

endpackage

// ===== src/pls_ram.sv =====
// ----------------------------------------------------------------------------
// pls_ram - generic single-write, single-read RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module pls_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== src/positional_list_store.sv =====
// ----------------------------------------------------------------------------
// positional_list_store - bounded ordered list with positional insert/remove
// Elements live in a RAM; a small sequencer shifts them one per cycle.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) takes one request word: req_type,
//   position, value. Output channel (out_valid/out_ready) returns result
//   words: status, element, last.
//   in_ready is high only while the sequencer is idle; one request is worked
//   on at a time.
//   Insert at p: (length - p) element moves, one per cycle through the RAM
//   read/write port pair, then the value write, then the result word.
//   Remove at p: (length - p - 1) element moves, then the result word.
//   Dump: per element a RAM read, then a load into the output register
//   (the read waits while that register is full), the last word flagged with last.
//   Errors (full, out of bounds, empty dump) go straight to the result word.
//   A request code of 3 is dropped with no result.
//   Reset clears the length and the control state; RAM contents are
//   undefined but only entries below the length are ever read.
//   A stalled receiver holds the output register; the sequencer waits
//   before loading the next word, so nothing is lost.
// ----------------------------------------------------------------------------
module positional_list_store (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [1:0]                       req_type,
    input  logic [pls_pkg::POS_W-1:0]        position,
    input  logic signed [pls_pkg::DATA_W-1:0] value,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [1:0]                       status,
    output logic signed [pls_pkg::DATA_W-1:0] element,
    output logic                             last
);

    import pls_pkg::*;

    // One-hot sequencer states
    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_MOVE = 6'b000010,   // shift elements, one per cycle
        S_FIN  = 6'b000100,   // store inserted value on insert, update length
        S_RESP = 6'b001000,   // single result word
        S_DRD  = 6'b010000,   // dump: read element
        S_DWR  = 6'b100000    // dump: load element into output register
    } state_t;

    state_t              state_reg, state_next;
    logic [LEN_W-1:0]    len_reg, len_next;
    logic [IDX_W-1:0]    src_reg, src_next;      // read cursor
    logic [IDX_W-1:0]    wa_reg, wa_next;        // pending write address
    logic                pend_reg, pend_next;    // write pending from last read
    logic [LEN_W-1:0]    cnt_reg, cnt_next;      // moves still to read
    logic                ins_reg, ins_next;      // insert (1) or remove (0)
    logic [IDX_W-1:0]    pos_reg, pos_next;
    logic [DATA_W-1:0]   val_reg, val_next;
    status_t             stat_reg, stat_next;

    logic                ovalid_reg, ovalid_next;
    logic [1:0]          ostat_reg, ostat_next;
    logic [DATA_W-1:0]   oelem_reg, oelem_next;
    logic                olast_reg, olast_next;

    logic                ram_we;
    logic [IDX_W-1:0]    ram_waddr;
    logic [DATA_W-1:0]   ram_wdata;
    logic [IDX_W-1:0]    ram_raddr;
    logic [DATA_W-1:0]   ram_rdata;

    logic                accept;
    logic                out_free;
    logic                load;
    logic [CMP_W-1:0]    ext_len;
    logic [CMP_W-1:0]    ext_pos;
    logic                dump_last;

    pls_ram #(
        .WIDTH (DATA_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;
    assign out_free  = !ovalid_reg || out_ready;
    assign ext_len   = CMP_W'(len_reg);
    assign ext_pos   = CMP_W'(position);
    assign dump_last = (LEN_W'(src_reg) == (len_reg - LEN_W'(1)));

    assign out_valid = ovalid_reg;
    assign status    = ostat_reg;
    assign element   = oelem_reg;
    assign last      = olast_reg;

    always_comb
    begin
        state_next = state_reg;
        len_next   = len_reg;
        src_next   = src_reg;
        wa_next    = wa_reg;
        pend_next  = pend_reg;
        cnt_next   = cnt_reg;
        ins_next   = ins_reg;
        pos_next   = pos_reg;
        val_next   = val_reg;
        stat_next  = stat_reg;
        ram_we     = 1'b0;
        ram_waddr  = wa_reg;
        ram_wdata  = ram_rdata;
        ram_raddr  = src_reg;
        load       = 1'b0;
        ostat_next = ostat_reg;
        oelem_next = oelem_reg;
        olast_next = olast_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    pos_next  = IDX_W'(position);
                    val_next  = value;
                    pend_next = 1'b0;
                    case (req_type)
                        REQ_INSERT:
                        begin
                            ins_next = 1'b1;
                            if (len_reg == LEN_W'(CAPACITY))
                            begin
                                stat_next  = ST_FULL;
                                state_next = S_RESP;
                            end
                            else if (ext_pos > ext_len)
                            begin
                                stat_next  = ST_OOB;
                                state_next = S_RESP;
                            end
                            else
                            begin
                                cnt_next   = len_reg - LEN_W'(position);
                                src_next   = IDX_W'(len_reg - LEN_W'(1));
                                state_next = S_MOVE;
                            end
                        end
                        REQ_REMOVE:
                        begin
                            ins_next = 1'b0;
                            if (len_reg == '0 || ext_pos >= ext_len)
                            begin
                                stat_next  = ST_OOB;
                                state_next = S_RESP;
                            end
                            else
                            begin
                                cnt_next   = len_reg - LEN_W'(1) - LEN_W'(position);
                                src_next   = IDX_W'(position) + IDX_W'(1);
                                state_next = S_MOVE;
                            end
                        end
                        REQ_DUMP:
                        begin
                            if (len_reg == '0)
                            begin
                                stat_next  = ST_EMPTY;
                                state_next = S_RESP;
                            end
                            else
                            begin
                                src_next   = '0;
                                state_next = S_DRD;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            S_MOVE:
            begin
                // write back the word read last cycle
                ram_we    = pend_reg;
                ram_waddr = wa_reg;
                ram_wdata = ram_rdata;
                if (cnt_reg != '0)
                begin
                    ram_raddr = src_reg;
                    pend_next = 1'b1;
                    cnt_next  = cnt_reg - LEN_W'(1);
                    if (ins_reg)
                    begin
                        wa_next  = src_reg + IDX_W'(1);
                        src_next = src_reg - IDX_W'(1);
                    end
                    else
                    begin
                        wa_next  = src_reg - IDX_W'(1);
                        src_next = src_reg + IDX_W'(1);
                    end
                end
                else
                begin
                    pend_next  = 1'b0;
                    state_next = S_FIN;
                end
            end

            S_FIN:
            begin
                stat_next = ST_OK;
                if (ins_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = pos_reg;
                    ram_wdata = val_reg;
                    len_next  = len_reg + LEN_W'(1);
                end
                else
                begin
                    len_next = len_reg - LEN_W'(1);
                end
                state_next = S_RESP;
            end

            S_RESP:
            begin
                if (out_free)
                begin
                    load       = 1'b1;
                    ostat_next = stat_reg;
                    oelem_next = '0;
                    olast_next = 1'b1;
                    state_next = S_IDLE;
                end
            end

            S_DRD:
            begin
                ram_raddr = src_reg;
                if (out_free)
                begin
                    state_next = S_DWR;
                end
            end

            S_DWR:
            begin
                load       = 1'b1;
                ostat_next = ST_OK;
                oelem_next = ram_rdata;
                olast_next = dump_last;
                src_next   = src_reg + IDX_W'(1);
                state_next = dump_last ? S_IDLE : S_DRD;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        ovalid_next = load || (ovalid_reg && !out_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            len_reg    <= '0;
            pend_reg   <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            len_reg    <= len_next;
            pend_reg   <= pend_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        src_reg   <= src_next;
        wa_reg    <= wa_next;
        cnt_reg   <= cnt_next;
        ins_reg   <= ins_next;
        pos_reg   <= pos_next;
        val_reg   <= val_next;
        stat_reg  <= stat_next;
        ostat_reg <= ostat_next;
        oelem_reg <= oelem_next;
        olast_reg <= olast_next;
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= LEN_W'(CAPACITY))
        else $error("length exceeds capacity");

    a_len_step: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(len_reg) |-> (len_reg == $past(len_reg) + LEN_W'(1) ||
                                len_reg == $past(len_reg) - LEN_W'(1)))
        else $error("length changed by more than one");

    a_dwr_free: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DWR |-> !ovalid_reg)
        else $error("dump load with output register occupied");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> out_free)
        else $error("output word overwritten");

endmodule
